>>> rtl/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

   // Frame head marker
   localparam logic [7:0] HEAD_BYTE = 8'hAA;

   // Payload capacity after reset
   localparam logic [15:0] CAP_RESET = 16'd56;

   // Result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Summary status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_HEAD      = 3'd1;
   localparam logic [2:0] ST_LEN_SHORT = 3'd2;
   localparam logic [2:0] ST_TOO_BIG   = 3'd3;
   localparam logic [2:0] ST_TRUNC     = 3'd4;

   // Input transaction
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic        msg_valid;
      logic [7:0]  msg_id;
      logic [15:0] pay_len;
      logic [2:0]  status;
      logic        crc_ok;
      logic        last;
   } rsp_type;

   // Results that the parser hands to the output queue for one byte
   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type res0;
      rsp_type res1;
   } push_type;

endpackage

`default_nettype wire

>>> rtl/crc32_frame_deframer_top.sv
`default_nettype none

// A byte's results pass through the input register and the output queue before rsp offers them.
// Throughput: one byte per cycle; a byte that yields a payload byte and a summary
// adds one result, and req stalls only while the three-entry output queue cannot take two.
// Reset: synchronous, active high; parser waits for a head byte, CRC is all ones,
// payload capacity returns to 56.

module crc32_frame_deframer_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cfd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cfd_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [15:0]      csr_data
);

   logic              in_vld_ff;
   cfd_pkg::req_type  in_ff;
   logic [15:0]       cap_ff;
   logic              room;
   logic              go;
   cfd_pkg::push_type push;

   assign csr_ready = 1'b1;
   assign go        = in_vld_ff && room;
   assign req_stall = in_vld_ff && !go;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cfd_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // Input register: load on a transaction, drop once parsed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_vld_ff <= 1'b1;
      end else if (go) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   cfd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .item     (in_ff),
      .capacity (cap_ff),
      .push     (push)
   );

   cfd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/cfd_core.sv
`default_nettype none

module cfd_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire cfd_pkg::req_type item,
   input  wire logic [15:0]      capacity,
   output cfd_pkg::push_type     push
);

   localparam logic [2:0] PH_HEAD = 3'd0;
   localparam logic [2:0] PH_CRC  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_ID   = 3'd3;
   localparam logic [2:0] PH_PAY  = 3'd4;
   localparam logic [2:0] PH_DROP = 3'd5;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   // Advance the reflected CRC-32 by one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  id_ff, id_in;
   logic [31:0] rcrc_ff, rcrc_in;
   logic [31:0] crc_ff, crc_in;
   logic [2:0]  fstat_ff, fstat_in;

   logic [7:0]       b;
   logic             eob;
   logic [31:0]      crc_nx;
   logic [15:0]      len_full;
   logic             fin;
   logic             skip;
   logic             summ_v;
   cfd_pkg::rsp_type summ;
   cfd_pkg::rsp_type res0;
   logic             push0;
   logic             have_len;
   logic             have_id;

   assign b        = item.in_byte;
   assign eob      = item.end_of_buffer;
   assign crc_nx   = crc_byte(crc_ff, b);
   assign len_full = {b, len_ff[7:0]};

   // Parse one byte
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      rcrc_in  = rcrc_ff;
      crc_in   = crc_ff;
      fstat_in = fstat_ff;
      fin      = 1'b0;
      skip     = 1'b0;
      summ_v   = 1'b0;
      summ     = '0;
      res0     = '0;
      push0    = 1'b0;
      have_len = 1'b0;
      have_id  = 1'b0;
      push     = '0;

      unique case (phase_ff)
         PH_HEAD: begin
            len_in   = '0;
            id_in    = '0;
            rcrc_in  = '0;
            crc_in   = '1;
            fstat_in = cfd_pkg::ST_OK;
            if (b != cfd_pkg::HEAD_BYTE) begin
               push0        = 1'b1;
               res0.kind    = cfd_pkg::KIND_SUMMARY;
               res0.status  = cfd_pkg::ST_HEAD;
               res0.last    = 1'b1;
               fin          = 1'b1;
            end else begin
               pos_in   = 17'd1;
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            rcrc_in = rcrc_ff | ({24'd0, b} << {pos_ff[1:0] - 2'd1, 3'b000});
            pos_in  = pos_ff + 17'd1;
            if (pos_ff >= 17'd4) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            crc_in = crc_nx;
            if (pos_ff == 17'd5) begin
               len_in = {8'd0, b};
               pos_in = 17'd6;
            end else begin
               len_in = len_full;
               pos_in = 17'd7;
               if (len_full < 16'd3) begin
                  push0       = 1'b1;
                  res0.kind   = cfd_pkg::KIND_SUMMARY;
                  res0.status = cfd_pkg::ST_LEN_SHORT;
                  res0.last   = 1'b1;
                  fin         = 1'b1;
               end else begin
                  fstat_in = ((len_full - 16'd3) > capacity) ? cfd_pkg::ST_TOO_BIG
                                                             : cfd_pkg::ST_OK;
                  phase_in = PH_ID;
               end
            end
         end
         PH_ID: begin
            crc_in = crc_nx;
            id_in  = b;
            pos_in = 17'd8;
            if (len_ff == 16'd3) begin
               fin = 1'b1;
            end else begin
               phase_in = PH_PAY;
            end
         end
         PH_PAY: begin
            crc_in = crc_nx;
            if (fstat_ff == cfd_pkg::ST_OK) begin
               push0          = 1'b1;
               res0.kind      = cfd_pkg::KIND_DATA;
               res0.data_byte = b;
            end
            if (pos_ff >= (17'd4 + {1'b0, len_ff})) begin
               fin = 1'b1;
            end else begin
               pos_in = pos_ff + 17'd1;
            end
         end
         default: begin
            // Drop bytes until the end of the buffer
            skip = 1'b1;
            if (eob) begin
               phase_in = PH_HEAD;
            end
         end
      endcase

      // Close the frame, or report truncation
      have_len = (phase_in == PH_ID) || (phase_in == PH_PAY);
      have_id  = (phase_in == PH_PAY);
      if (!skip) begin
         if (fin) begin
            if (have_len) begin
               summ_v         = 1'b1;
               summ.kind      = cfd_pkg::KIND_SUMMARY;
               summ.msg_valid = 1'b1;
               summ.msg_id    = id_in;
               summ.pay_len   = len_in - 16'd3;
               summ.status    = fstat_in;
               summ.crc_ok    = (~crc_in == rcrc_in);
               summ.last      = 1'b1;
            end
            phase_in = eob ? PH_HEAD : PH_DROP;
         end else if (eob) begin
            summ_v         = 1'b1;
            summ.kind      = cfd_pkg::KIND_SUMMARY;
            summ.msg_valid = have_id;
            summ.msg_id    = have_id ? id_in : 8'd0;
            summ.pay_len   = have_len ? (len_in - 16'd3) : 16'd0;
            summ.status    = cfd_pkg::ST_TRUNC;
            summ.last      = 1'b1;
            phase_in       = PH_HEAD;
         end
      end

      // Pack results in order, summary after any data byte
      if (go) begin
         if (push0) begin
            push.push0 = 1'b1;
            push.res0  = res0;
            push.push1 = summ_v;
            push.res1  = summ;
         end else begin
            push.push0 = summ_v;
            push.res0  = summ;
         end
      end
   end

   // Hold state unless a byte advances
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         pos_ff   <= '0;
         len_ff   <= '0;
         id_ff    <= '0;
         rcrc_ff  <= '0;
         crc_ff   <= '1;
         fstat_ff <= cfd_pkg::ST_OK;
      end else if (go) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         rcrc_ff  <= rcrc_in;
         crc_ff   <= crc_in;
         fstat_ff <= fstat_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cfd_outq.sv
`default_nettype none

module cfd_outq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfd_pkg::push_type push,
   output logic                   room,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cfd_pkg::rsp_type       rsp_data
);

   cfd_pkg::rsp_type q_ff [3];
   cfd_pkg::rsp_type q_in [3];
   logic [1:0]       cnt_ff, cnt_in;
   logic [1:0]       c1;
   logic             pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign c1        = cnt_ff - {1'b0, pop};
   assign room      = (c1 <= 2'd1);

   // Shift out the head, append new results behind the survivors
   always_comb begin
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = pop ? q_ff[2] : q_ff[1];
      q_in[2] = q_ff[2];
      if (push.push0) begin
         q_in[c1] = push.res0;
      end
      if (push.push1) begin
         q_in[c1 + 2'd1] = push.res1;
      end
      cnt_in = c1 + {1'b0, push.push0} + {1'b0, push.push1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

`ifndef ASSERT_OFF
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0 && push.res1.last)
      else $error("second result of a byte is not a summary behind a first one");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> room)
      else $error("result pushed without room in the queue");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) && pop && !push.push0 |=> !rsp_valid)
      else $error("queue shows a result after its last one left");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 2000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cfd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cfd_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [15:0]      csr_data = '0;

   // quiet_phase and hold_request are shared between the stimulus and the result-side stall process
   logic        quiet_phase = 1'b0;
   logic        hold_request = 1'b0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   logic [7:0]  frame_bytes[$];

   typedef enum logic [2:0] {
      WAIT_HEAD, GET_CRC, GET_LEN, GET_ID, GET_PAYLOAD, SKIP_REST
   } parse_type;

   // Tracks the deframer's parse state and the results each byte should produce
   class frame_tracker;
      parse_type        phase;
      logic [16:0]      position;
      logic [15:0]      frame_len;
      logic [7:0]       frame_id;
      logic [31:0]      field_crc;
      logic [31:0]      calc_crc;
      logic [2:0]       frame_status;
      logic [15:0]      capacity;
      cfd_pkg::rsp_type pending_results[$];
      int               errors;
      int               checked;

      function new();
         phase        = WAIT_HEAD;
         position     = '0;
         frame_len    = '0;
         frame_id     = '0;
         field_crc    = '0;
         calc_crc     = '1;
         frame_status = cfd_pkg::ST_OK;
         capacity     = cfd_pkg::CAP_RESET;
         errors       = 0;
         checked      = 0;
      endfunction

      // Reflected CRC-32, one byte
      static function logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'h0, b};
         for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
         return r;
      endfunction

      function void add_summary(logic valid, logic [7:0] id, logic [15:0] size,
                                logic [2:0] status, logic crc_ok);
         cfd_pkg::rsp_type r;
         r           = '0;
         r.kind      = cfd_pkg::KIND_SUMMARY;
         r.msg_valid = valid;
         r.msg_id    = id;
         r.pay_len   = size;
         r.status    = status;
         r.crc_ok    = crc_ok;
         r.last      = 1'b1;
         pending_results.push_back(r);
      endfunction

      function void add_data(logic [7:0] b);
         cfd_pkg::rsp_type r;
         r           = '0;
         r.kind      = cfd_pkg::KIND_DATA;
         r.data_byte = b;
         pending_results.push_back(r);
      endfunction

      // Advance the parser by one accepted byte
      function void take_byte(cfd_pkg::req_type t);
         logic [7:0] b;
         logic [1:0] lane;
         logic       done;
         logic       have_len;
         b    = t.in_byte;
         done = 1'b0;
         case (phase)
            WAIT_HEAD: begin
               frame_len    = '0;
               frame_id     = '0;
               field_crc    = '0;
               calc_crc     = '1;
               frame_status = cfd_pkg::ST_OK;
               if (b != cfd_pkg::HEAD_BYTE) begin
                  add_summary(1'b0, 8'h00, 16'h0000, cfd_pkg::ST_HEAD, 1'b0);
                  done = 1'b1;
               end else begin
                  position = 17'd1;
                  phase    = GET_CRC;
               end
            end
            GET_CRC: begin
               lane = position[1:0] - 2'd1;
               field_crc[8*lane +: 8] = b;
               position++;
               if (position >= 17'd5) phase = GET_LEN;
            end
            GET_LEN: begin
               calc_crc = crc32_next(calc_crc, b);
               if (position == 17'd5) begin
                  frame_len = {8'h00, b};
                  position  = 17'd6;
               end else begin
                  frame_len[15:8] = b;
                  position        = 17'd7;
                  if (frame_len < 16'd3) begin
                     add_summary(1'b0, 8'h00, 16'h0000, cfd_pkg::ST_LEN_SHORT, 1'b0);
                     done = 1'b1;
                  end else begin
                     frame_status = (frame_len - 16'd3 > capacity) ? cfd_pkg::ST_TOO_BIG
                                                                   : cfd_pkg::ST_OK;
                     phase        = GET_ID;
                  end
               end
            end
            GET_ID: begin
               calc_crc = crc32_next(calc_crc, b);
               frame_id = b;
               position = 17'd8;
               if (frame_len == 16'd3) done = 1'b1;
               else phase = GET_PAYLOAD;
            end
            GET_PAYLOAD: begin
               calc_crc = crc32_next(calc_crc, b);
               if (frame_status == cfd_pkg::ST_OK) add_data(b);
               if (position >= 17'd4 + frame_len) done = 1'b1;
               else position++;
            end
            default: begin
               // drop until the end of the buffer
               if (t.end_of_buffer) phase = WAIT_HEAD;
               return;
            end
         endcase

         if (done) begin
            if (phase == GET_ID || phase == GET_PAYLOAD)
               add_summary(1'b1, frame_id, frame_len - 16'd3, frame_status,
                           ~calc_crc == field_crc);
            phase = t.end_of_buffer ? WAIT_HEAD : SKIP_REST;
         end else if (t.end_of_buffer) begin
            // buffer ended inside the frame
            have_len = (phase == GET_ID || phase == GET_PAYLOAD);
            add_summary(phase == GET_PAYLOAD, (phase == GET_PAYLOAD) ? frame_id : 8'h00,
                        have_len ? frame_len - 16'd3 : 16'h0000, cfd_pkg::ST_TRUNC, 1'b0);
            phase = WAIT_HEAD;
         end
      endfunction

      task report(string what);
         errors++;
         $display("ERROR: %s", what);
      endtask

      task compare_field(string field, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                             checked, field, got, want));
      endtask

      // Compare one result transaction against the oldest expectation
      task match_result(cfd_pkg::rsp_type got);
         cfd_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected: %p", checked, got));
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("data_byte", got.data_byte, want.data_byte);
            compare_field("msg_valid", got.msg_valid, want.msg_valid);
            compare_field("msg_id", got.msg_id, want.msg_id);
            compare_field("pay_len", got.pay_len, want.pay_len);
            compare_field("status", got.status, want.status);
            compare_field("crc_ok", got.crc_ok, want.crc_ok);
            compare_field("last", got.last, want.last);
         end
         checked++;
      endtask
   endclass

   frame_tracker tracker;

   // Mostly short gaps, a few long ones; none in a quiet phase
   function automatic int idle_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_payload(int cap);
      int top;
      top = (cap < 64) ? cap : 64;
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return top;
         2:       return $urandom_range(0, top);
         default: return $urandom_range(0, (top < 16) ? top : 16);
      endcase
   endfunction

   // Build head, CRC field, length, id and npay random payload bytes
   function automatic void make_frame(logic [15:0] len, int npay);
      logic [7:0]  body[$];
      logic [31:0] c;
      body = {};
      body.push_back(len[7:0]);
      body.push_back(len[15:8]);
      body.push_back(8'($urandom));
      repeat (npay) body.push_back(8'($urandom));
      c = '1;
      foreach (body[i]) c = frame_tracker::crc32_next(c, body[i]);
      c = ~c;
      frame_bytes = {cfd_pkg::HEAD_BYTE, c[7:0], c[15:8], c[23:16], c[31:24]};
      foreach (body[i]) frame_bytes.push_back(body[i]);
   endfunction

   // Offer one byte and hold it until the transaction completes
   task automatic send_byte(input logic [7:0] value, input logic eob);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: value, end_of_buffer: eob};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_buffer(input int count);
      for (int i = 0; i < count; i++) send_byte(frame_bytes[i], i == count - 1);
      bytes_sent += count;
   endtask

   // Write the capacity once every expected result is back
   task automatic write_capacity(input logic [15:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed frames, the rest broken buffers and noise
   task automatic random_buffer(input int cap);
      int r, n, cut;
      r   = $urandom_range(0, 99);
      cut = 0;
      if (r < 55) begin
         n = pick_payload(cap);
         make_frame(16'(n + 3), n);
         if ($urandom_range(0, 9) == 0)
            frame_bytes[$urandom_range(1, 4)] ^= 8'(1 << $urandom_range(0, 7));
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom));
      end else if (r < 67) begin
         // end the buffer inside a frame
         if ($urandom_range(0, 4) == 0) begin
            make_frame(16'($urandom_range(3, 65535)), $urandom_range(0, 12));
         end else begin
            n = pick_payload(cap);
            make_frame(16'(n + 3), n);
         end
         cut = $urandom_range(1, frame_bytes.size() - 1);
      end else if (r < 75) begin
         // wrong head byte, then bytes to drop
         frame_bytes = {};
         do n = $urandom_range(0, 255); while (n == cfd_pkg::HEAD_BYTE);
         frame_bytes.push_back(8'(n));
         repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
      end else if (r < 83) begin
         make_frame(16'($urandom_range(0, 2)), $urandom_range(0, 3));
      end else if (r < 93) begin
         if (cap < 48) begin
            n = cap + 1 + $urandom_range(0, 8);
            make_frame(16'(n + 3), n);
         end else begin
            make_frame(16'($urandom_range(3, 65535)), $urandom_range(0, 12));
         end
      end else begin
         frame_bytes = {};
         repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      end
      send_buffer((cut == 0) ? frame_bytes.size() : cut);
   endtask

   crc32_frame_deframer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Observe every transaction and watch for a stuck block
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.take_byte(req_data);
         if (rsp_valid && !rsp_stall) tracker.match_result(rsp_data);
         if (csr_valid && csr_ready) tracker.capacity = csr_data;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   // Result-side stalls, plus one long hold-off on request
   initial begin
      int hold;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            hold = idle_gap();
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat (quiet_phase ? 16 : $urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Stimulus
   initial begin
      int cap_plan[6];
      int phase_start;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Wrong head with end of buffer on it, then wrong head with a dropped byte
      frame_bytes = {8'h00};
      send_buffer(1);
      frame_bytes = {8'hFF, 8'h12};
      send_buffer(2);
      // buffer ends inside the CRC field
      frame_bytes = {cfd_pkg::HEAD_BYTE, 8'h34};
      send_buffer(2);
      // zero length field, end of buffer on its second byte
      make_frame(16'd0, 0);
      send_buffer(7);
      // id only, no payload
      make_frame(16'd3, 0);
      send_buffer(frame_bytes.size());
      // one payload byte with a bad CRC field
      make_frame(16'd4, 1);
      frame_bytes[2] ^= 8'h80;
      send_buffer(frame_bytes.size());

      cap_plan = '{56, 0, 65535, 3, $urandom_range(1, 40), 56};
      for (int p = 0; p < 6; p++) begin
         if (p > 0) write_capacity(16'(cap_plan[p]));
         quiet_phase = (p == 3);
         if (p == 2) begin
            // back up the result side while a long frame streams in
            hold_request = 1'b1;
            make_frame(16'd63, 60);
            send_buffer(frame_bytes.size());
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 260) random_buffer(cap_plan[p]);
      end

      // Drain and let any late result show up
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
